>>> rtl/irm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_pkg - shared types and codes of the I2C register access master
// Command codes, byte count width and the word carried from the front end
// to the bus sequencer.
// ----------------------------------------------------------------------------
package irm_pkg;

   // command codes on the op field
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // classified word kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // byte counter width, covers counts up to seven
   localparam int BYTES_W = 3;

   localparam int ADDR_W = 7;
   localparam int DATA_W = 16;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         reg_addr;
      logic [DATA_W-1:0]  write_data;
      logic [BYTES_W-1:0] count;
      logic               sda_in;
   } item_type;

endpackage

>>> rtl/irm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_front - request front end
// Accepts request words, decodes the command, clamps the byte count and
// holds the result in a two-entry queue for the bus sequencer.
// ----------------------------------------------------------------------------
module irm_front #(
   parameter int MAX_BYTES = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [7:0]                   req_reg_addr,
   input  logic [irm_pkg::DATA_W-1:0]   req_write_data,
   input  logic [1:0]                   req_byte_count,
   input  logic                         req_sda_in,
   output logic                         q_valid,
   output irm_pkg::item_type            q_item,
   input  logic                         q_pop
);

   irm_pkg::item_type q_mem_ff [2];
   irm_pkg::item_type item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic [irm_pkg::BYTES_W-1:0] bc_ext;

   // command decode and byte count clamp
   always_comb begin
      bc_ext = {{(irm_pkg::BYTES_W-2){1'b0}}, req_byte_count};
      item_in.reg_addr   = req_reg_addr;
      item_in.write_data = req_write_data;
      item_in.sda_in     = req_sda_in;
      unique case (req_op)
         irm_pkg::OP_WRITE: item_in.kind = irm_pkg::KIND_WRITE;
         irm_pkg::OP_READ:  item_in.kind = irm_pkg::KIND_READ;
         default:           item_in.kind = irm_pkg::KIND_TICK;
      endcase
      if (bc_ext == '0) begin
         item_in.count = irm_pkg::BYTES_W'(1);
      end else if (bc_ext > irm_pkg::BYTES_W'(MAX_BYTES)) begin
         item_in.count = irm_pkg::BYTES_W'(MAX_BYTES);
      end else begin
         item_in.count = bc_ext;
      end
   end

   // queue control
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

>>> rtl/irm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_back - bus sequencer
// Takes one queued word per step, advances the SCL/SDA line sequence by one
// phase and registers the response word.
// ----------------------------------------------------------------------------
module irm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [irm_pkg::ADDR_W-1:0]   csr_wr_data,
   input  logic                         q_valid,
   input  irm_pkg::item_type            q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_scl,
   output logic                         rsp_sda_out,
   output logic                         rsp_sda_drive,
   output logic                         rsp_busy_res,
   output logic                         rsp_done_res,
   output logic                         rsp_nack_error,
   output logic [irm_pkg::DATA_W-1:0]   rsp_read_data
);

   // line phase codes
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_TX_LO  = 4'd1;
   localparam logic [3:0] PH_TX_HI  = 4'd2;
   localparam logic [3:0] PH_ACK_LO = 4'd3;
   localparam logic [3:0] PH_ACK_HI = 4'd4;
   localparam logic [3:0] PH_RS_LO  = 4'd5;
   localparam logic [3:0] PH_RS_HI  = 4'd6;
   localparam logic [3:0] PH_RS_ST  = 4'd7;
   localparam logic [3:0] PH_RX_LO  = 4'd8;
   localparam logic [3:0] PH_RX_HI  = 4'd9;
   localparam logic [3:0] PH_MA_LO  = 4'd10;
   localparam logic [3:0] PH_MA_HI  = 4'd11;
   localparam logic [3:0] PH_SP_LO  = 4'd12;
   localparam logic [3:0] PH_SP_HI  = 4'd13;
   localparam logic [3:0] PH_SP_REL = 4'd14;

   // byte stage codes
   localparam logic [1:0] STG_ADDR_W = 2'd0;
   localparam logic [1:0] STG_REG    = 2'd1;
   localparam logic [1:0] STG_DATA   = 2'd2;
   localparam logic [1:0] STG_ADDR_R = 2'd3;

   localparam int BW = irm_pkg::BYTES_W;
   localparam int DW = irm_pkg::DATA_W;

   logic [irm_pkg::ADDR_W-1:0] dev_addr_ff;
   logic [3:0]    phase_ff, phase_in;
   logic [2:0]    bit_index_ff, bit_index_in;
   logic [BW-1:0] bytes_left_ff, bytes_left_in;
   logic          is_read_ff, is_read_in;
   logic [7:0]    reg_ptr_ff, reg_ptr_in;
   logic [DW-1:0] write_word_ff, write_word_in;
   logic [DW-1:0] read_word_ff, read_word_in;
   logic [7:0]    tx_byte_ff, tx_byte_in;
   logic [1:0]    tx_stage_ff, tx_stage_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          drive_ff, drive_in;
   logic          done_ff, done_in;
   logic          nack_ff, nack_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          step;
   logic          tx_bit;
   logic          master_nack;
   logic [BW-1:0] bl_dec;

   // data byte still to be sent, counted from the top byte down
   function automatic logic [7:0] data_byte(input logic [BW-1:0] left,
                                            input logic [DW-1:0] word);
      logic [1:0]  k;
      logic [31:0] wide;
      begin
         k    = (left == '0) ? 2'd0 : 2'(left - BW'(1));
         wide = {{(32-DW){1'b0}}, word};
         data_byte = wide[{k, 3'b000} +: 8];
      end
   endfunction

   // one step per queued word, whenever the response register is free
   assign step   = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop  = step;
   assign tx_bit = tx_byte_ff[bit_index_ff];
   assign master_nack = !(bytes_left_ff > BW'(1));
   assign bl_dec = (bytes_left_ff == '0) ? bytes_left_ff : bytes_left_ff - BW'(1);

   // line sequencer
   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      bytes_left_in = bytes_left_ff;
      is_read_in    = is_read_ff;
      reg_ptr_in    = reg_ptr_ff;
      write_word_in = write_word_ff;
      read_word_in  = read_word_ff;
      tx_byte_in    = tx_byte_ff;
      tx_stage_in   = tx_stage_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      done_in       = 1'b0;
      nack_in       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (q_item.kind == irm_pkg::KIND_WRITE || q_item.kind == irm_pkg::KIND_READ) begin
               is_read_in    = (q_item.kind == irm_pkg::KIND_READ);
               reg_ptr_in    = q_item.reg_addr;
               write_word_in = q_item.write_data;
               bytes_left_in = q_item.count;
               read_word_in  = '0;
               scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
               tx_stage_in   = STG_ADDR_W;
               tx_byte_in    = {dev_addr_ff, 1'b0};
               bit_index_in  = 3'd7;
               phase_in      = PH_TX_LO;
            end
         end
         PH_TX_LO: begin
            scl_in = 1'b0; sda_in = tx_bit; drive_in = 1'b1;
            phase_in = PH_TX_HI;
         end
         PH_TX_HI: begin
            scl_in = 1'b1; sda_in = tx_bit; drive_in = 1'b1;
            if (bit_index_ff == 3'd0) begin
               phase_in = PH_ACK_LO;
            end else begin
               bit_index_in = bit_index_ff - 3'd1;
               phase_in     = PH_TX_LO;
            end
         end
         PH_ACK_LO: begin
            scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
            phase_in = PH_ACK_HI;
         end
         PH_ACK_HI: begin
            scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            if (q_item.sda_in) begin
               // target did not acknowledge: abort
               done_in  = 1'b1;
               nack_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               case (tx_stage_ff)
                  STG_ADDR_W: begin
                     tx_stage_in  = STG_REG;
                     tx_byte_in   = reg_ptr_ff;
                     bit_index_in = 3'd7;
                     phase_in     = PH_TX_LO;
                  end
                  STG_REG: begin
                     if (is_read_ff) begin
                        phase_in = PH_RS_LO;
                     end else begin
                        tx_stage_in  = STG_DATA;
                        tx_byte_in   = data_byte(bytes_left_ff, write_word_ff);
                        bit_index_in = 3'd7;
                        phase_in     = PH_TX_LO;
                     end
                  end
                  STG_DATA: begin
                     bytes_left_in = bl_dec;
                     if (bl_dec != '0) begin
                        tx_stage_in  = STG_DATA;
                        tx_byte_in   = data_byte(bl_dec, write_word_ff);
                        bit_index_in = 3'd7;
                        phase_in     = PH_TX_LO;
                     end else begin
                        phase_in = PH_SP_LO;
                     end
                  end
                  default: begin
                     bit_index_in = 3'd7;
                     phase_in     = PH_RX_LO;
                  end
               endcase
            end
         end
         PH_RS_LO: begin
            scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
            phase_in = PH_RS_HI;
         end
         PH_RS_HI: begin
            scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            phase_in = PH_RS_ST;
         end
         PH_RS_ST: begin
            // repeated start, then address with read bit
            scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
            tx_stage_in  = STG_ADDR_R;
            tx_byte_in   = {dev_addr_ff, 1'b1};
            bit_index_in = 3'd7;
            phase_in     = PH_TX_LO;
         end
         PH_RX_LO: begin
            scl_in = 1'b0; sda_in = 1'b1; drive_in = 1'b0;
            phase_in = PH_RX_HI;
         end
         PH_RX_HI: begin
            scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            read_word_in = {read_word_ff[DW-2:0], q_item.sda_in};
            if (bit_index_ff == 3'd0) begin
               phase_in = PH_MA_LO;
            end else begin
               bit_index_in = bit_index_ff - 3'd1;
               phase_in     = PH_RX_LO;
            end
         end
         PH_MA_LO: begin
            scl_in = 1'b0; sda_in = master_nack; drive_in = 1'b1;
            phase_in = PH_MA_HI;
         end
         PH_MA_HI: begin
            scl_in = 1'b1; sda_in = master_nack; drive_in = 1'b1;
            if (!master_nack) begin
               bytes_left_in = bytes_left_ff - BW'(1);
               bit_index_in  = 3'd7;
               phase_in      = PH_RX_LO;
            end else begin
               phase_in = PH_SP_LO;
            end
         end
         PH_SP_LO: begin
            scl_in = 1'b0; sda_in = 1'b0; drive_in = 1'b1;
            phase_in = PH_SP_HI;
         end
         PH_SP_HI: begin
            scl_in = 1'b1; sda_in = 1'b0; drive_in = 1'b1;
            phase_in = PH_SP_REL;
         end
         PH_SP_REL: begin
            // stop condition
            scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            scl_in = 1'b1; sda_in = 1'b1; drive_in = 1'b0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   // response valid: set on a step, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // sequencer state, which doubles as the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= 3'd0;
         bytes_left_ff <= '0;
         is_read_ff    <= 1'b0;
         reg_ptr_ff    <= 8'd0;
         write_word_ff <= '0;
         read_word_ff  <= '0;
         tx_byte_ff    <= 8'd0;
         tx_stage_ff   <= STG_ADDR_W;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b0;
         done_ff       <= 1'b0;
         nack_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff      <= phase_in;
            bit_index_ff  <= bit_index_in;
            bytes_left_ff <= bytes_left_in;
            is_read_ff    <= is_read_in;
            reg_ptr_ff    <= reg_ptr_in;
            write_word_ff <= write_word_in;
            read_word_ff  <= read_word_in;
            tx_byte_ff    <= tx_byte_in;
            tx_stage_ff   <= tx_stage_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            drive_ff      <= drive_in;
            done_ff       <= done_in;
            nack_ff       <= nack_in;
         end
      end
   end

   // device address register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= irm_pkg::ADDR_W'(72);
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = scl_ff;
   assign rsp_sda_out    = sda_ff;
   assign rsp_sda_drive  = drive_ff;
   assign rsp_busy_res   = (phase_ff != PH_IDLE);
   assign rsp_done_res   = done_ff;
   assign rsp_nack_error = nack_ff;
   assign rsp_read_data  = read_word_ff;

endmodule

>>> rtl/i2c_register_access_master_core.sv
`timescale 1ns / 1ps
// An accepted word is written into the two-entry queue and then taken by the
// sequencer, which registers its response word; words queued ahead and a stall
// on the response hold it back, and while a pending response stalls no word is taken.
// Throughput otherwise one word per clock cycle, set by the single-step sequencer.
// Reset: synchronous, active high; clears the queue, returns the bus to idle
// with SCL high and SDA released, and loads the device address with 72.
// ----------------------------------------------------------------------------
// i2c_register_access_master_core - I2C register read/write master
// Front end decodes and queues request words; the back end steps the bus
// one line phase per word and returns one response word for each.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core #(
   parameter int MAX_BYTES = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [irm_pkg::ADDR_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_reg_addr,
   input  logic [irm_pkg::DATA_W-1:0]  req_write_data,
   input  logic [1:0]                  req_byte_count,
   input  logic                        req_sda_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_scl,
   output logic                        rsp_sda_out,
   output logic                        rsp_sda_drive,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic                        rsp_nack_error,
   output logic [irm_pkg::DATA_W-1:0]  rsp_read_data
);

   logic              q_valid;
   logic              q_pop;
   irm_pkg::item_type q_item;

   // request decode and queue
   irm_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_byte_count (req_byte_count),
      .req_sda_in     (req_sda_in),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // bus sequencer and response register
   irm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_nack_error (rsp_nack_error),
      .rsp_read_data  (rsp_read_data)
   );

endmodule
